// ----- sv/hlw_pkg.sv -----
// Shared types, constants and the digit conversion for the hex word loader.
// Used by the front end, the command queue, the back end and the top level.
package hlw_pkg;

  // Label table size; a power of two, so a label number wraps by its low bits
  localparam int LABEL_ENTRIES = 256;
  localparam int LABEL_BITS    = $clog2(LABEL_ENTRIES);
  // Width of the word counter and of each label table entry (at most 30)
  localparam int COUNT_BITS    = 24;

  localparam logic [31:0] LOAD_BASE_RESET = 32'h0000_4000;
  localparam logic [31:0] BRANCH_OPCODE   = 32'hEB00_0000;
  localparam logic [31:0] BRANCH_BASE     = 32'hFFFF_FFFE;
  localparam logic [31:0] OFFSET_MASK     = 32'h00FF_FFFF;

  localparam logic [7:0] CH_START   = 8'h02;
  localparam logic [7:0] CH_END     = 8'h03;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LOWER   = 8'h20;
  localparam logic [7:0] CH_ALPHA   = 8'h57;
  localparam logic [7:0] CH_LC_X    = 8'h78;
  localparam logic [7:0] CH_UC_X    = 8'h58;
  localparam logic [7:0] CH_LC_J    = 8'h6A;
  localparam logic [7:0] CH_UC_J    = 8'h4A;

  typedef enum logic [1:0] {
    LBL_NONE,
    LBL_DEFINE,
    LBL_BRANCH
  } lbl_mode_t;

  typedef enum logic [1:0] {
    CMD_DIGIT,
    CMD_END,
    CMD_DEFINE,
    CMD_BRANCH
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t               op;
    logic [7:0]            digit;
    logic [LABEL_BITS-1:0] label;
  } cmd_t;

  // No validity test: letters fold to lower case, everything wraps mod 256
  function automatic logic [7:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    if (c > CH_NINE) begin
      d = (c | CH_LOWER) - CH_ALPHA;
    end else begin
      d = c - CH_ZERO;
    end
    return d;
  endfunction

endpackage

// ----- sv/hex_word_loader_with_branch_labels.sv -----
// Top level of the hex word loader: classifier, command queue, word builder.
// Depends on hlw_pkg, hlw_front, hlw_cmdq, hlw_back and hlw_ram.
//
// Usage:
//   Input channel: one received character per beat on in_rx_char, taken
//   at an edge with in_push high and in_full low. Nothing is loaded until
//   the start byte 0x02; the end byte 0x03, unless taken as a label digit, yields an end-marker result
//   (out_kind = 1) and every later character is dropped.
//   Result channel: while out_empty is low the oldest result is on
//   out_kind / out_store_address / out_store_word; out_pop takes it.
//   Config: cfg_we with cfg_load_base writes the base byte address of word
//   zero; write it only while the block is idle.
//   Throughput: one character per cycle, sustained while results are popped, including branch words.
//   Path: a character is classified into the command queue, then built into
//   the result stage (with the label table read), then queued as a result.
//   The label table read is registered, so branch words finish in the
//   result stage; one RAM port pair sets that timing.
//   Stall: if out_pop stays low, the two-entry result queue, the result
//   stage and the two-entry command queue fill, then in_full rises.
//   Reset (synchronous, rst_n low): all framing state clears, load_base
//   returns to 0x4000, the word count to zero, and every label reads as
//   zero through per-entry valid bits; no clearing pass is needed.
module hex_word_loader_with_branch_labels (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_rx_char,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_kind,
  output logic [31:0] out_store_address,
  output logic [31:0] out_store_word,
  input  logic        cfg_we,
  input  logic [31:0] cfg_load_base
);
  import hlw_pkg::*;

  logic cmd_push;
  cmd_t cmd_data;
  logic cmdq_full;
  logic cmd_pop;
  logic cmd_empty;
  cmd_t cmd_head;

  // the input side stalls only when the command queue is full
  assign in_full = cmdq_full;

  // front: framing, comments, label prefixes -> commands
  hlw_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_rx_char (in_rx_char),
    .cmdq_full  (cmdq_full),
    .cmd_push   (cmd_push),
    .cmd_data   (cmd_data)
  );

  // decouple classification from word building
  hlw_cmdq u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_data),
    .full      (cmdq_full),
    .pop       (cmd_pop),
    .empty     (cmd_empty),
    .head      (cmd_head)
  );

  // back: nibble packing, word count, label table, result queue
  hlw_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_load_base     (cfg_load_base),
    .cmd_empty         (cmd_empty),
    .cmd_head          (cmd_head),
    .cmd_pop           (cmd_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_kind          (out_kind),
    .out_store_address (out_store_address),
    .out_store_word    (out_store_word)
  );

`ifndef SYNTH
  // the classifier never pushes into a full command queue
  a_cmd_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push |-> !cmdq_full)
    else $error("command pushed into full queue");

  // the builder only takes a command that is there
  a_cmd_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !cmd_empty)
    else $error("command popped from empty queue");

  // the end marker is the last result ever queued
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pop && !out_empty && out_kind) |=> out_empty)
    else $error("result follows the end marker");
`endif

endmodule

// ----- sv/hlw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hlw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/hlw_front.sv -----
// Character classifier: start/end framing, comments, label prefixes.
// Turns each accepted character into at most one command; uses hlw_pkg.
module hlw_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  input  logic [7:0]    in_rx_char,
  input  logic          cmdq_full,
  output logic          cmd_push,
  output hlw_pkg::cmd_t cmd_data
);
  import hlw_pkg::*;

  logic      started_r, started_nxt;
  logic      finished_r, finished_nxt;
  logic      comment_r, comment_nxt;
  lbl_mode_t mode_r, mode_nxt;
  logic      seen_r, seen_nxt;
  logic [3:0] first_r, first_nxt;

  logic       accept;
  logic [7:0] d;
  logic [7:0] lbl8;

  assign accept = in_push && !cmdq_full;
  assign d      = digit_of(in_rx_char);
  // the whole converted digit ORs in, so its upper nibble lands on the first one
  assign lbl8   = {first_r | d[7:4], d[3:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r  <= 1'b0;
      finished_r <= 1'b0;
      comment_r  <= 1'b0;
      mode_r     <= LBL_NONE;
      seen_r     <= 1'b0;
      first_r    <= '0;
    end else begin
      started_r  <= started_nxt;
      finished_r <= finished_nxt;
      comment_r  <= comment_nxt;
      mode_r     <= mode_nxt;
      seen_r     <= seen_nxt;
      first_r    <= first_nxt;
    end
  end

  always_comb begin
    logic in_cmt;
    started_nxt    = started_r;
    finished_nxt   = finished_r;
    comment_nxt    = comment_r;
    mode_nxt       = mode_r;
    seen_nxt       = seen_r;
    first_nxt      = first_r;
    cmd_push       = 1'b0;
    cmd_data.op    = CMD_DIGIT;
    cmd_data.digit = d;
    cmd_data.label = lbl8[LABEL_BITS-1:0];
    in_cmt         = comment_r || (in_rx_char == CH_HASH);

    if (accept && !finished_r) begin
      if (!started_r) begin
        if (in_rx_char == CH_START) begin
          started_nxt = 1'b1;
        end
      end else if (mode_r == LBL_DEFINE || mode_r == LBL_BRANCH) begin
        // both label characters are taken as digits, whatever they are
        if (!seen_r) begin
          first_nxt = d[3:0];
          seen_nxt  = 1'b1;
        end else begin
          cmd_push    = 1'b1;
          cmd_data.op = (mode_r == LBL_DEFINE) ? CMD_DEFINE : CMD_BRANCH;
          mode_nxt    = LBL_NONE;
          seen_nxt    = 1'b0;
          first_nxt   = '0;
        end
      end else begin
        mode_nxt = LBL_NONE;
        if (in_rx_char == CH_END) begin
          finished_nxt = 1'b1;
          cmd_push     = 1'b1;
          cmd_data.op  = CMD_END;
        end else if (in_cmt) begin
          comment_nxt = (in_rx_char != CH_NEWLINE);
        end else if (in_rx_char == CH_LC_X || in_rx_char == CH_UC_X) begin
          mode_nxt = LBL_DEFINE;
          seen_nxt = 1'b0;
        end else if (in_rx_char == CH_LC_J || in_rx_char == CH_UC_J) begin
          mode_nxt = LBL_BRANCH;
          seen_nxt = 1'b0;
        end else if (in_rx_char >= CH_ZERO) begin
          cmd_push = 1'b1;
        end
      end
    end
  end

endmodule

// ----- sv/hlw_cmdq.sv -----
// Two-entry command queue between the classifier and the word builder.
// Uses hlw_pkg for the command type.
module hlw_cmdq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  hlw_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output hlw_pkg::cmd_t head
);
  import hlw_pkg::*;

  cmd_t       ent_r [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = ent_r[rd_r];

  always_comb begin
    wr_nxt  = push ? ~wr_r : wr_r;
    rd_nxt  = pop ? ~rd_r : rd_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_r] <= push_data;
    end
  end

endmodule

// ----- sv/hlw_back.sv -----
// Word builder: packs nibbles, keeps the word count and label table, forms
// branch words and queues results. Uses hlw_pkg and hlw_ram.
module hlw_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [31:0]   cfg_load_base,
  input  logic          cmd_empty,
  input  hlw_pkg::cmd_t cmd_head,
  output logic          cmd_pop,
  output logic          out_empty,
  input  logic          out_pop,
  output logic          out_kind,
  output logic [31:0]   out_store_address,
  output logic [31:0]   out_store_word
);
  import hlw_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [31:0] addr;
    logic [31:0] word;
  } result_t;

  logic [31:0]            base_r, base_nxt;
  logic [31:0]            acc_r, acc_nxt;
  logic [2:0]             pos_r, pos_nxt;
  logic [COUNT_BITS-1:0]  count_r, count_nxt;
  logic [LABEL_ENTRIES-1:0] valid_r, valid_nxt;

  // result stage: holds one result, branch words finish here with table data
  logic                  b_valid_r, b_valid_nxt;
  logic                  b_branch_r, b_branch_nxt;
  logic                  b_hit_r, b_hit_nxt;
  logic [COUNT_BITS-1:0] b_count_r, b_count_nxt;
  result_t               b_res_r, b_res_nxt;

  result_t    ofifo_r [2];
  logic       owr_r, ord_r;
  logic [1:0] ocnt_r;
  logic       ofull;
  logic       opop;

  logic                  go;
  logic                  b_adv;
  logic                  b_load;
  logic                  tbl_we;
  logic                  tbl_re;
  logic [COUNT_BITS-1:0] tbl_rdata;
  logic [31:0]           addr_cur;
  logic [31:0]           sum;
  logic [31:0]           tbl_val;
  logic [31:0]           gap;
  logic [31:0]           offset;
  result_t               b_out;

  assign ofull    = (ocnt_r == 2'd2);
  assign out_empty = (ocnt_r == 2'd0);
  assign opop     = out_pop && !out_empty;
  assign b_adv    = b_valid_r && !ofull;
  assign go       = !cmd_empty && (!b_valid_r || !ofull);
  assign cmd_pop  = go;
  assign tbl_we   = go && (cmd_head.op == CMD_DEFINE);
  assign tbl_re   = go && (cmd_head.op == CMD_BRANCH);

  assign addr_cur = base_r + 32'({count_r, 2'b00});
  assign sum      = acc_r + (32'(cmd_head.digit) << {pos_r, 2'b00});

  hlw_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (LABEL_ENTRIES)
  ) u_label_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (cmd_head.label),
    .wdata (count_r),
    .re    (tbl_re),
    .raddr (cmd_head.label),
    .rdata (tbl_rdata)
  );

  always_comb begin
    base_nxt     = cfg_we ? cfg_load_base : base_r;
    acc_nxt      = acc_r;
    pos_nxt      = pos_r;
    count_nxt    = count_r;
    valid_nxt    = valid_r;
    b_load       = 1'b0;
    b_branch_nxt = b_branch_r;
    b_hit_nxt    = b_hit_r;
    b_count_nxt  = b_count_r;
    b_res_nxt    = b_res_r;

    if (go) begin
      unique case (cmd_head.op)
        CMD_DIGIT: begin
          if (pos_r == 3'd0) begin
            b_load         = 1'b1;
            b_branch_nxt   = 1'b0;
            b_res_nxt.kind = 1'b0;
            b_res_nxt.addr = addr_cur;
            b_res_nxt.word = sum;
            acc_nxt        = '0;
            pos_nxt        = 3'd7;
            count_nxt      = count_r + COUNT_BITS'(1);
          end else begin
            acc_nxt = sum;
            pos_nxt = pos_r - 3'd1;
          end
        end
        CMD_END: begin
          b_load         = 1'b1;
          b_branch_nxt   = 1'b0;
          b_res_nxt.kind = 1'b1;
          b_res_nxt.addr = '0;
          b_res_nxt.word = '0;
        end
        CMD_DEFINE: begin
          valid_nxt[cmd_head.label] = 1'b1;
        end
        CMD_BRANCH: begin
          b_load         = 1'b1;
          b_branch_nxt   = 1'b1;
          b_hit_nxt      = valid_r[cmd_head.label];
          b_count_nxt    = count_r;
          b_res_nxt.kind = 1'b0;
          b_res_nxt.addr = addr_cur;
          b_res_nxt.word = '0;
          count_nxt      = count_r + COUNT_BITS'(1);
        end
        default: begin
        end
      endcase
    end

    b_valid_nxt = b_load ? 1'b1 : (b_adv ? 1'b0 : b_valid_r);
  end

  // never-written labels read as zero
  assign tbl_val = b_hit_r ? 32'(tbl_rdata) : 32'd0;
  assign gap     = 32'(b_count_r) - tbl_val;
  assign offset  = (BRANCH_BASE - gap) & OFFSET_MASK;

  always_comb begin
    b_out = b_res_r;
    if (b_branch_r) begin
      b_out.word = BRANCH_OPCODE | offset;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r    <= LOAD_BASE_RESET;
      acc_r     <= '0;
      pos_r     <= 3'd7;
      count_r   <= '0;
      valid_r   <= '0;
      b_valid_r <= 1'b0;
    end else begin
      base_r    <= base_nxt;
      acc_r     <= acc_nxt;
      pos_r     <= pos_nxt;
      count_r   <= count_nxt;
      valid_r   <= valid_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_branch_r <= b_branch_nxt;
    b_hit_r    <= b_hit_nxt;
    b_count_r  <= b_count_nxt;
    b_res_r    <= b_res_nxt;
  end

  // two-entry result queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_r  <= 1'b0;
      ord_r  <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      if (b_adv) begin
        owr_r <= ~owr_r;
      end
      if (opop) begin
        ord_r <= ~ord_r;
      end
      ocnt_r <= ocnt_r + {1'b0, b_adv} - {1'b0, opop};
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      ofifo_r[owr_r] <= b_out;
    end
  end

  assign out_kind          = ofifo_r[ord_r].kind;
  assign out_store_address = ofifo_r[ord_r].addr;
  assign out_store_word    = ofifo_r[ord_r].word;

endmodule

// ----- tb/tb_hex_word_loader_with_branch_labels.sv -----
// Self-checking bench for the hex word loader: streams characters through the queue
// ports, predicts every stored word, branch word and end marker, and checks each result.
// Depends on hlw_pkg and hex_word_loader_with_branch_labels.
module tb_hex_word_loader_with_branch_labels;
  import hlw_pkg::*;

  localparam logic KIND_WORD = 1'b0;
  localparam logic KIND_END  = 1'b1;
  // Margin for results still passing the queues and result stage before touching config
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_STALL    = 300;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int MAX_PRINTS    = 50;

  typedef struct packed {
    logic        kind;
    logic [31:0] addr;
    logic [31:0] word;
  } store_beat_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [7:0]  in_rx_char = 8'h00;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic        out_kind;
  logic [31:0] out_store_address;
  logic [31:0] out_store_word;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_load_base = 32'h0;

  // Stimulus and scoreboard bookkeeping
  logic [7:0]  rx_chars[$];
  store_beat_t pending_stores[$];
  store_beat_t popped_store;
  int          chars_queued = 0;
  int          chars_taken = 0;
  int          mismatches = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 24;
  int          recv_idle_pct = 77;
  logic        stall_go = 1'b0;
  logic        recv_hold = 1'b0;

  // Loader state as the bench sees it
  logic [31:0]           lb_base = LOAD_BASE_RESET;
  logic                  lb_started = 1'b0;
  logic                  lb_done = 1'b0;
  logic                  lb_in_comment = 1'b0;
  lbl_mode_t             lb_lbl_mode = LBL_NONE;
  logic                  lb_lbl_half = 1'b0;
  logic [3:0]            lb_lbl_hi = 4'h0;
  logic [31:0]           lb_acc = 32'h0;
  logic [2:0]            lb_nib_pos = 3'd7;
  logic [COUNT_BITS-1:0] lb_count = '0;
  logic [COUNT_BITS-1:0] lb_labels [LABEL_ENTRIES] = '{default: '0};

  hex_word_loader_with_branch_labels dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_rx_char        (in_rx_char),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_kind          (out_kind),
    .out_store_address (out_store_address),
    .out_store_word    (out_store_word),
    .cfg_we            (cfg_we),
    .cfg_load_base     (cfg_load_base)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Hex value of a character with no validity test: letters fold to lower case,
  // anything else is plain subtraction from '0', all modulo 256.
  function automatic logic [7:0] hex_value(input logic [7:0] c);
    if (c > CH_NINE) begin
      return (c | CH_LOWER) - CH_ALPHA;
    end
    return c - CH_ZERO;
  endfunction

  // Queue a store at the current word count, then advance the count (it wraps).
  function automatic void push_store_word(input logic [31:0] w);
    pending_stores.push_back('{KIND_WORD, lb_base + (32'(lb_count) << 2), w});
    lb_count = lb_count + COUNT_BITS'(1);
  endfunction

  // Advance the loader state by one accepted character and queue what it yields.
  function automatic void decode_rx_char(input logic [7:0] c);
    logic [7:0]  d;
    logic [7:0]  lbl;
    logic [31:0] gap;
    d = hex_value(c);
    // Drop everything once the end byte has been seen
    if (lb_done) begin
      return;
    end
    // Drop everything up to the start byte
    if (!lb_started) begin
      if (c == CH_START) begin
        lb_started = 1'b1;
      end
      return;
    end
    // Label digits: taken as digits whatever the character is, end byte included
    if (lb_lbl_mode == LBL_DEFINE || lb_lbl_mode == LBL_BRANCH) begin
      if (!lb_lbl_half) begin
        lb_lbl_hi   = d[3:0];
        lb_lbl_half = 1'b1;
        return;
      end
      // Full second value is ORed in, so its upper nibble can disturb the label
      lbl = {lb_lbl_hi, 4'h0} | d;
      lb_lbl_half = 1'b0;
      lb_lbl_hi   = 4'h0;
      if (lb_lbl_mode == LBL_DEFINE) begin
        lb_lbl_mode = LBL_NONE;
        lb_labels[lbl[LABEL_BITS-1:0]] = lb_count;
        return;
      end
      lb_lbl_mode = LBL_NONE;
      gap = 32'(lb_count) - 32'(lb_labels[lbl[LABEL_BITS-1:0]]);
      push_store_word(BRANCH_OPCODE | ((BRANCH_BASE - gap) & OFFSET_MASK));
      return;
    end
    lb_lbl_mode = LBL_NONE;
    // End byte wins even inside a comment
    if (c == CH_END) begin
      lb_done = 1'b1;
      pending_stores.push_back('{KIND_END, 32'h0, 32'h0});
      return;
    end
    if (c == CH_HASH) begin
      lb_in_comment = 1'b1;
    end
    if (lb_in_comment) begin
      if (c == CH_NEWLINE) begin
        lb_in_comment = 1'b0;
      end
      return;
    end
    if (c == CH_LC_X || c == CH_UC_X) begin
      lb_lbl_mode = LBL_DEFINE;
      lb_lbl_half = 1'b0;
      return;
    end
    if (c == CH_LC_J || c == CH_UC_J) begin
      lb_lbl_mode = LBL_BRANCH;
      lb_lbl_half = 1'b0;
      return;
    end
    // Whitespace, control bytes and a repeated start byte are skipped
    if (c < CH_ZERO) begin
      return;
    end
    // Full 8-bit value is added, so non-hex characters carry into higher nibbles
    lb_acc = lb_acc + (32'(d) << (4 * lb_nib_pos));
    if (lb_nib_pos == 3'd0) begin
      push_store_word(lb_acc);
      lb_acc     = 32'h0;
      lb_nib_pos = 3'd7;
    end else begin
      lb_nib_pos = lb_nib_pos - 3'd1;
    end
  endfunction

  function automatic void put(input logic [7:0] c);
    rx_chars.push_back(c);
    chars_queued++;
  endfunction

  function automatic logic [7:0] rand_hex_char();
    int r;
    r = $urandom_range(21);
    if (r < 10) begin
      return 8'(CH_ZERO + r);
    end else if (r < 16) begin
      return 8'("a" + r - 10);
    end
    return 8'("A" + r - 16);
  endfunction

  // Any byte that can neither end the stream, close a comment nor open a label,
  // so a random token never leaves a label pending in front of the end byte.
  function automatic logic [7:0] rand_plain_byte();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    if (c == CH_END || c == CH_NEWLINE || c == CH_LC_X || c == CH_UC_X ||
        c == CH_LC_J || c == CH_UC_J) begin
      c = 8'hA5;
    end
    return c;
  endfunction

  // Two label digits, mostly a small hex label so defines and branches meet
  function automatic void put_label_digits();
    if ($urandom_range(99) < 80) begin
      put(8'(CH_ZERO + $urandom_range(3)));
      put(rand_hex_char());
    end else begin
      put(rand_plain_byte());
      put(rand_plain_byte());
    end
  endfunction

  // Mostly well-formed hex text with labels, branches and comments; some noise
  function automatic void queue_random_text(input int n);
    int first;
    int pick;
    int k;
    logic [7:0] c;
    first = chars_queued;
    while (chars_queued - first < n) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        put(rand_hex_char());
      end else if (pick < 65) begin
        case ($urandom_range(3))
          0: put(8'h20);
          1: put(CH_NEWLINE);
          2: put(8'h0D);
          default: put(8'h09);
        endcase
      end else if (pick < 71) begin
        put(CH_HASH);
        k = $urandom_range(6);
        repeat (k) put(rand_plain_byte());
        put(CH_NEWLINE);
      end else if (pick < 78) begin
        put($urandom_range(1) ? CH_LC_X : CH_UC_X);
        put_label_digits();
      end else if (pick < 87) begin
        put($urandom_range(1) ? CH_LC_J : CH_UC_J);
        put_label_digits();
      end else if (pick < 94) begin
        put(rand_plain_byte());
      end else begin
        c = 8'("g" + $urandom_range(19));
        if (c == CH_LC_X || c == CH_LC_J) begin
          c = "q";
        end
        put(c);
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < MAX_PRINTS) begin
      $display("mismatch %s: got %08h want %08h, cycle %0d", what, got, want, cycle_count);
    end
    mismatches++;
  endtask

  // Hold off until every queued character is in and every result is out,
  // then give the pipeline time to swallow characters that yield nothing.
  task automatic drain_stores();
    while (chars_taken != chars_queued) @(posedge clk);
    while (pending_stores.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_load_base(input logic [31:0] v);
    @(posedge clk);
    cfg_we        <= 1'b1;
    cfg_load_base <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    lb_base = v;
  endtask

  // Driver: predict on each accepted beat, hold the beat while full, then
  // offer the next character unless the sender idles this cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        decode_rx_char(in_rx_char);
        chars_taken++;
      end
      if (in_push && in_full) begin
        // hold push and data until the beat is taken
      end else if (rx_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_push    <= 1'b1;
        in_rx_char <= rx_chars.pop_front();
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // Monitor: check each popped beat against the oldest expectation, field by field
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (pending_stores.size() == 0) begin
          report_mismatch("result with nothing expected", out_store_word, 32'h0);
        end else begin
          popped_store = pending_stores.pop_front();
          if (out_kind !== popped_store.kind) begin
            report_mismatch("kind", 32'(out_kind), 32'(popped_store.kind));
          end
          if (out_store_address !== popped_store.addr) begin
            report_mismatch("store_address", out_store_address, popped_store.addr);
          end
          if (out_store_word !== popped_store.word) begin
            report_mismatch("store_word", out_store_word, popped_store.word);
          end
        end
      end
      out_pop <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Long receiver hold-off so the block backs up and raises full
  initial begin
    wait (stall_go);
    @(posedge clk);
    recv_hold <= 1'b1;
    repeat (LONG_STALL) @(posedge clk);
    recv_hold <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed text under the reset base address
    put(8'hFF);                       // ignored before start
    put(CH_END);                      // end byte before start is ignored too
    put(CH_START);
    put(CH_START);                    // repeated start is just skipped
    put("F"); put("f"); put("0"); put("9");
    put("A"); put("a"); put("7"); put("0");
    put(CH_LC_X); put("0"); put("1"); // label one at count one
    put(CH_HASH); put(CH_NEWLINE);    // empty comment
    put(CH_LC_J); put("0"); put("1"); // branch with zero distance
    put(CH_UC_X); put(CH_END); put(CH_HASH); // end byte and hash as label digits
    put(CH_UC_J); put(8'hFF); put(8'h80);    // branch to a label never defined
    queue_random_text(300);
    drain_stores();

    // Top address: store addresses wrap
    write_load_base(32'hFFFF_FFFF);
    send_idle_pct = 77;
    recv_idle_pct = 24;
    queue_random_text(300);
    drain_stores();

    // Base zero, no idling, with the long receiver stall up front
    write_load_base(32'h0000_0000);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_go = 1'b1;
    queue_random_text(300);
    drain_stores();

    write_load_base($urandom);
    queue_random_text(300);
    put(CH_END);
    put(CH_START);                    // all dropped after the end byte
    put(CH_LC_X);
    put("5");
    drain_stores();

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/hlw_pkg.sv
sv/hlw_ram.sv
sv/hlw_front.sv
sv/hlw_cmdq.sv
sv/hlw_back.sv
sv/hex_word_loader_with_branch_labels.sv
tb/tb_hex_word_loader_with_branch_labels.sv
